[hdl/reading_to_segment_codes_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the reading to segment codes core
// Each macro samples on clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef READING_TO_SEGMENT_CODES_CORE_MACROS_SVH
`define READING_TO_SEGMENT_CODES_CORE_MACROS_SVH

// Check that a condition holds at every sampled edge outside reset
`define RTSC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("rtsc assertion failed");

// Check that an antecedent implies a consequent (the consequent may open with a delay)
`define RTSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("rtsc implication failed");

`endif

[hdl/rtsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_pkg
// Types, limits and segment maps shared by the reading to segment codes core.
// ----------------------------------------------------------------------------
package rtsc_pkg;

  // Temperature window, format boundaries and humidity limit, in tenths
  localparam logic signed [15:0] T_HIGH_LIMIT     = 16'sd1501;
  localparam logic signed [15:0] T_LOW_LIMIT      = -16'sd550;
  localparam logic signed [15:0] T_WIDE_START     = 16'sd1000;
  localparam logic signed [15:0] T_NEG_WIDE_START = -16'sd100;
  localparam logic signed [15:0] H_HIGH_LIMIT     = 16'sd1000;

  // Segment codes
  localparam logic [7:0] T_DOT     = 8'h10;
  localparam logic [7:0] H_DOT     = 8'h01;
  localparam logic [7:0] SEG_E     = 8'h4F;
  localparam logic [7:0] SEG_R     = 8'h42;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_H_NINE = 8'hBE;

  // Magnitude width: covers the largest in-range value (1500)
  localparam int unsigned MAG_W = 11;

  // Display format of the temperature group
  typedef enum logic [2:0] {
    TC_ERR  = 3'd0,
    TC_WIDE = 3'd1,
    TC_POS  = 3'd2,
    TC_NEGS = 3'd3,
    TC_NEGW = 3'd4
  } tclass_e;

  typedef struct packed {
    logic signed [15:0] temp_tenths;
    logic signed [15:0] humidity_tenths;
  } req_t;

  typedef struct packed {
    logic [7:0] temp_seg_high;
    logic [7:0] temp_seg_mid;
    logic [7:0] temp_seg_low;
    logic [7:0] hum_seg_high;
    logic [7:0] hum_seg_mid;
    logic [7:0] hum_seg_low;
  } res_t;

  // Decimal digits of a magnitude up to 1999
  typedef struct packed {
    logic       thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Temperature group segment map
  function automatic logic [7:0] temp_seg(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hAF;
      4'd1:    s = 8'hA0;
      4'd2:    s = 8'hCB;
      4'd3:    s = 8'hE9;
      4'd4:    s = 8'hE4;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h6F;
      4'd7:    s = 8'hA8;
      4'd8:    s = 8'hEF;
      4'd9:    s = 8'hED;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Humidity group segment map
  function automatic logic [7:0] hum_seg(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hFA;
      4'd1:    s = 8'h0A;
      4'd2:    s = 8'hD6;
      4'd3:    s = 8'h9E;
      4'd4:    s = 8'h2E;
      4'd5:    s = 8'hBC;
      4'd6:    s = 8'hFC;
      4'd7:    s = 8'h1A;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hBE;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

[hdl/rtsc_digit_split.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_digit_split
// Three-stage split of a magnitude (0..1599) into decimal digits, using
// reciprocal multiplies by 1/100 and 1/10 with a subtract after each.
// ----------------------------------------------------------------------------
module rtsc_digit_split (
  input  wire logic                        clk_i,
  input  wire logic [rtsc_pkg::MAG_W-1:0]  mag_i,
  output rtsc_pkg::digits_t                digits_o
);

  // Stage A: quotient by 100 (m * 5243 >> 19 is exact over the range)
  logic [23:0]                 prod100;
  logic [3:0]                  q100_d, q100_q;
  logic [rtsc_pkg::MAG_W-1:0]  mag_q;

  assign prod100 = 24'(mag_i) * 24'd5243;
  assign q100_d  = prod100[22:19];

  always_ff @(posedge clk_i) begin
    q100_q <= q100_d;
    mag_q  <= mag_i;
  end

  // Stage B: remainder by 100, split quotient into thousands and hundreds
  logic [rtsc_pkg::MAG_W-1:0]  rem_full;
  logic [6:0]                  rem_d, rem_q;
  logic                        thou_d, thou_q;
  logic [3:0]                  hund_d, hund_q;

  assign rem_full = mag_q - (rtsc_pkg::MAG_W'(q100_q) * rtsc_pkg::MAG_W'(100));
  assign rem_d    = rem_full[6:0];
  assign thou_d   = (q100_q >= 4'd10);
  assign hund_d   = thou_d ? (q100_q - 4'd10) : q100_q;

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    thou_q <= thou_d;
    hund_q <= hund_d;
  end

  // Stage C: tens by reciprocal (r * 205 >> 11), ones by subtract
  logic [14:0]      prod10;
  logic [3:0]       tens_d;
  logic [6:0]       ones_full;
  rtsc_pkg::digits_t digits_d, digits_q;

  assign prod10    = 15'(rem_q) * 15'd205;
  assign tens_d    = prod10[14:11];
  assign ones_full = rem_q - (7'(tens_d) * 7'd10);

  always_comb begin
    digits_d.thou = thou_q;
    digits_d.hund = hund_q;
    digits_d.tens = tens_d;
    digits_d.ones = ones_full[3:0];
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
  end

  assign digits_o = digits_q;

endmodule
`default_nettype wire

[hdl/reading_to_segment_codes_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reading_to_segment_codes_core
// Converts a temperature and a humidity reading, both in tenths, into six
// LCD segment bytes (three digits per group).
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_i and raise start_i for one cycle per reading. A transaction is
//   taken at each rising edge where start_i is high and busy_o is low; busy_o
//   stays low, so a new reading may enter in every cycle.
//   The result appears on res_o with valid_o high for exactly one cycle, once
//   the reading has passed five register stages (classify, divide by 100,
//   remainder and hundreds, tens and ones, segment mapping).
//   Throughput is one reading per cycle; results leave in input order.
//   The receiver cannot stall: it must take res_o in the cycle valid_o is
//   high. Reset (rst_ni low, asynchronous) clears all stage valid bits, so no
//   result is produced for transactions that were in flight.
//   Out-of-range temperature shows E r r; humidity outside 1..999 tenths shows 9 9 9.
// ----------------------------------------------------------------------------
`include "reading_to_segment_codes_core_macros.svh"

module reading_to_segment_codes_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire rtsc_pkg::req_t req_i,
  output logic               valid_o,
  output rtsc_pkg::res_t     res_o
);

  logic accept;

  // Never hold off new transactions
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Stage 1: classify both readings, take magnitudes
  logic signed [15:0]           temp;
  logic signed [15:0]           hum;
  logic [15:0]                  temp_neg;
  rtsc_pkg::tclass_e            tclass_d, tclass1_q, tclass2_q, tclass3_q, tclass4_q;
  logic                         hok_d, hok1_q, hok2_q, hok3_q, hok4_q;
  logic [rtsc_pkg::MAG_W-1:0]   tmag_d, tmag_q;
  logic [rtsc_pkg::MAG_W-1:0]   hmag_d, hmag_q;
  logic                         v1_q, v2_q, v3_q, v4_q, v5_q;

  assign temp     = req_i.temp_tenths;
  assign hum      = req_i.humidity_tenths;
  assign temp_neg = -temp;

  always_comb begin
    priority if (temp >= rtsc_pkg::T_HIGH_LIMIT || temp < rtsc_pkg::T_LOW_LIMIT) begin
      tclass_d = rtsc_pkg::TC_ERR;
    end else if (temp >= rtsc_pkg::T_WIDE_START) begin
      tclass_d = rtsc_pkg::TC_WIDE;
    end else if (temp >= 16'sd0) begin
      tclass_d = rtsc_pkg::TC_POS;
    end else if (temp > rtsc_pkg::T_NEG_WIDE_START) begin
      tclass_d = rtsc_pkg::TC_NEGS;
    end else begin
      tclass_d = rtsc_pkg::TC_NEGW;
    end
  end

  assign tmag_d = temp[15] ? temp_neg[rtsc_pkg::MAG_W-1:0] : temp[rtsc_pkg::MAG_W-1:0];
  assign hok_d  = (hum > 16'sd0) && (hum < rtsc_pkg::H_HIGH_LIMIT);
  assign hmag_d = hum[rtsc_pkg::MAG_W-1:0];

  always_ff @(posedge clk_i) begin
    tclass1_q <= tclass_d;
    hok1_q    <= hok_d;
    tmag_q    <= tmag_d;
    hmag_q    <= hmag_d;
  end

  // Advance valid bits through all stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stages 2 to 4: digit extraction, with format codes carried alongside
  rtsc_pkg::digits_t tdig;
  rtsc_pkg::digits_t hdig;

  rtsc_digit_split u_temp_split (
    .clk_i    (clk_i),
    .mag_i    (tmag_q),
    .digits_o (tdig)
  );

  rtsc_digit_split u_hum_split (
    .clk_i    (clk_i),
    .mag_i    (hmag_q),
    .digits_o (hdig)
  );

  always_ff @(posedge clk_i) begin
    tclass2_q <= tclass1_q;
    tclass3_q <= tclass2_q;
    tclass4_q <= tclass3_q;
    hok2_q    <= hok1_q;
    hok3_q    <= hok2_q;
    hok4_q    <= hok3_q;
  end

  // Stage 5: map digits to segment bytes
  rtsc_pkg::res_t res_d, res_q;

  always_comb begin
    unique case (tclass4_q)
      rtsc_pkg::TC_WIDE: begin
        res_d.temp_seg_high = rtsc_pkg::temp_seg({3'b000, tdig.thou}) | rtsc_pkg::T_DOT;
        res_d.temp_seg_mid  = rtsc_pkg::temp_seg(tdig.hund);
        res_d.temp_seg_low  = rtsc_pkg::temp_seg(tdig.tens);
      end
      rtsc_pkg::TC_POS: begin
        res_d.temp_seg_high = (tdig.hund == 4'd0) ? rtsc_pkg::T_DOT
                            : (rtsc_pkg::temp_seg(tdig.hund) | rtsc_pkg::T_DOT);
        res_d.temp_seg_mid  = rtsc_pkg::temp_seg(tdig.tens) | rtsc_pkg::T_DOT;
        res_d.temp_seg_low  = rtsc_pkg::temp_seg(tdig.ones);
      end
      rtsc_pkg::TC_NEGS: begin
        res_d.temp_seg_high = rtsc_pkg::SEG_MINUS | rtsc_pkg::T_DOT;
        res_d.temp_seg_mid  = rtsc_pkg::temp_seg(tdig.tens) | rtsc_pkg::T_DOT;
        res_d.temp_seg_low  = rtsc_pkg::temp_seg(tdig.ones);
      end
      rtsc_pkg::TC_NEGW: begin
        res_d.temp_seg_high = rtsc_pkg::SEG_MINUS | rtsc_pkg::T_DOT;
        res_d.temp_seg_mid  = rtsc_pkg::temp_seg(tdig.hund);
        res_d.temp_seg_low  = rtsc_pkg::temp_seg(tdig.tens);
      end
      default: begin
        res_d.temp_seg_high = rtsc_pkg::SEG_E;
        res_d.temp_seg_mid  = rtsc_pkg::SEG_R;
        res_d.temp_seg_low  = rtsc_pkg::SEG_R;
      end
    endcase

    if (hok4_q) begin
      res_d.hum_seg_high = (hdig.hund == 4'd0) ? rtsc_pkg::H_DOT
                         : (rtsc_pkg::hum_seg(hdig.hund) | rtsc_pkg::H_DOT);
      res_d.hum_seg_mid  = rtsc_pkg::hum_seg(hdig.tens) | rtsc_pkg::H_DOT;
      res_d.hum_seg_low  = rtsc_pkg::hum_seg(hdig.ones) | rtsc_pkg::H_DOT;
    end else begin
      res_d.hum_seg_high = rtsc_pkg::SEG_H_NINE;
      res_d.hum_seg_mid  = rtsc_pkg::SEG_H_NINE;
      res_d.hum_seg_low  = rtsc_pkg::SEG_H_NINE;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = v5_q;
  assign res_o   = res_q;

  // Every accepted transaction yields a result
  `RTSC_ASSERT_IMP(a_result_follows, accept, ##5 valid_o)
  // No result appears without an earlier accepted transaction
  `RTSC_ASSERT_IMP(a_no_spurious, !accept, ##5 !valid_o)
  // Middle and low humidity dot bits are lit together or not at all
  `RTSC_ASSERT_IMP(a_hum_dots, valid_o, (res_o.hum_seg_mid[0] == res_o.hum_seg_low[0]))
  // A minus sign is never followed by a dotted rightmost digit
  `RTSC_ASSERT_IMP(a_neg_low_nodot,
    valid_o && (res_o.temp_seg_high == (rtsc_pkg::SEG_MINUS | rtsc_pkg::T_DOT)),
    (res_o.temp_seg_low[4] == 1'b0))

endmodule
`default_nettype wire
